FILE: hdl/stcs_pkg.sv
`default_nettype none

package stcs_pkg;

    localparam int unsigned NUM_CHECKS = 5;
    localparam int unsigned MS_W       = 20;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned REQ_W      = 8;
    localparam int unsigned CELLS_W    = 2;
    localparam int unsigned PHASE_W    = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = MS_W;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_POLL  = 1'b1;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_CELLS      = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CONSENSUS  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_TRANSMIT   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_HANDSET    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SOLENOID   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CONFIRMED  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TIMEOUT    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_FAIL_CELLS = 4'd8;
    localparam logic [PHASE_W-1:0] PH_FAIL_LAST  = 4'd12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_TO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONS_TO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_TO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HS_TO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SOL_TO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_TX    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_USE = 3'd7;

    // Reset values of the configuration registers
    localparam logic [MS_W-1:0]    DEADLINE_RST = 20'd60000;
    localparam logic [MS_W-1:0]    TIMEOUT_RST  = 20'd10000;
    localparam logic [REQ_W-1:0]   REQ_TX_RST   = 8'd3;
    localparam logic [CELLS_W-1:0] CELLS_RST    = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] now_ms;
        logic              cell_one_ok;
        logic              cell_two_ok;
        logic              cell_three_ok;
        logic              consensus_ok;
        logic [CNT_W-1:0]  transmit_count;
        logic [CNT_W-1:0]  bus_init_count;
        logic [CNT_W-1:0]  bus_id_count;
        logic              solenoid_ok;
    } in_item_t;

    typedef struct packed {
        logic [PHASE_W-1:0]    phase;
        logic [NUM_CHECKS-1:0] pass_flags;
        logic                  confirm_pulse;
        logic                  reboot_pulse;
    } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/stcs_in_if.sv
`default_nettype none

interface stcs_in_if;
    logic                valid;
    logic                ready;
    stcs_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/stcs_out_if.sv
`default_nettype none

interface stcs_out_if;
    logic                valid;
    logic                ready;
    stcs_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/self_test_confirm_sequencer.sv
// Channel   Direction  Handshake      Payload
// in_ch     sink       valid/ready    cmd, now_ms, cell flags, counters, solenoid_ok
// out_ch    source     valid/ready    phase, pass_flags, confirm_pulse, reboot_pulse
// cfg       write      cfg_write      cfg_index (3 bits), cfg_data (20 bits)
//
// One item per cycle sustained while the output is not stalled. The check cascade works
// from the input register in the cycle after the input transfer and loads the result
// register at the end of that cycle unless the output is stalled.
// All five checks are evaluated side by side and a priority pick finds the first
// failing check combinationally, so the cascade never iterates.
// Reset (rst_n low, asynchronous) restores idle state and register defaults.
// A stalled output holds both stages; the input stays ready while a stage is free.

`default_nettype none

module self_test_confirm_sequencer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [stcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [stcs_pkg::CFG_DATA_W-1:0]    cfg_data,
    stcs_in_if.sink                                 in_ch,
    stcs_out_if.source                              out_ch
);

    localparam int unsigned N  = stcs_pkg::NUM_CHECKS;
    localparam int unsigned MW = stcs_pkg::MS_W;
    localparam int unsigned TW = stcs_pkg::TIME_W;

    // Configuration registers
    logic [MW-1:0]                    deadline_reg;
    logic [MW-1:0]                    timeout_reg [N];
    logic [stcs_pkg::REQ_W-1:0]       req_tx_reg;
    logic [stcs_pkg::CELLS_W-1:0]     cells_reg;

    // Sequencer state
    logic [stcs_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [N-1:0]                     pass_reg, pass_next;
    logic [TW-1:0]                    start_time_reg, start_time_next;
    logic [TW-1:0]                    chk_start_reg, chk_start_next;
    logic [MW-1:0]                    budget_reg, budget_next;
    logic [stcs_pkg::CNT_W-1:0]       tx_base_reg, tx_base_next;
    logic [stcs_pkg::CNT_W-1:0]       rx_base_reg, rx_base_next;

    // Pipeline registers
    logic                             s1_valid_reg;
    stcs_pkg::in_item_t               s1_reg;
    logic                             out_valid_reg;
    stcs_pkg::out_item_t              out_reg, out_next;

    logic                             advance;
    logic                             fire;

    // Check cascade signals
    logic [N-1:0]                     chk_ok;
    logic [stcs_pkg::CNT_W:0]         hs_wide;
    logic [stcs_pkg::CNT_W-1:0]       hs_sum;
    logic [TW-1:0]                    elapsed;
    logic [TW-1:0]                    spent;
    logic                             expired;
    logic [MW-1:0]                    left;
    logic [2:0]                       first_idx;
    logic [2:0]                       fail_idx;
    logic                             found;
    logic [MW-1:0]                    fail_to;
    logic                             fails;
    logic [MW-1:0]                    start_budget;

    assign advance      = !out_valid_reg || out_ch.ready;
    assign fire         = s1_valid_reg && advance;
    assign in_ch.ready  = !s1_valid_reg || advance;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg <= stcs_pkg::DEADLINE_RST;
            for (int i = 0; i < N; i++)
            begin
                timeout_reg[i] <= stcs_pkg::TIMEOUT_RST;
            end
            req_tx_reg <= stcs_pkg::REQ_TX_RST;
            cells_reg  <= stcs_pkg::CELLS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                stcs_pkg::CFG_DEADLINE:  deadline_reg   <= cfg_data;
                stcs_pkg::CFG_CELL_TO:   timeout_reg[0] <= cfg_data;
                stcs_pkg::CFG_CONS_TO:   timeout_reg[1] <= cfg_data;
                stcs_pkg::CFG_TX_TO:     timeout_reg[2] <= cfg_data;
                stcs_pkg::CFG_HS_TO:     timeout_reg[3] <= cfg_data;
                stcs_pkg::CFG_SOL_TO:    timeout_reg[4] <= cfg_data;
                stcs_pkg::CFG_REQ_TX:    req_tx_reg     <= cfg_data[stcs_pkg::REQ_W-1:0];
                stcs_pkg::CFG_CELLS_USE: cells_reg      <= cfg_data[stcs_pkg::CELLS_W-1:0];
                default:                 cells_reg      <= cells_reg;
            endcase
        end
    end

    // Shared by the start baseline and the handset check: saturating sum.
    always_comb
    begin
        hs_wide = {1'b0, s1_reg.bus_init_count} + {1'b0, s1_reg.bus_id_count};
        hs_sum  = hs_wide[stcs_pkg::CNT_W] ? '1 : hs_wide[stcs_pkg::CNT_W-1:0];
    end

    always_comb
    begin
        chk_ok[0] = s1_reg.cell_one_ok
                    && (cells_reg < 2'd2 || s1_reg.cell_two_ok)
                    && (cells_reg < 2'd3 || s1_reg.cell_three_ok);
        chk_ok[1] = s1_reg.consensus_ok;
        chk_ok[2] = (s1_reg.transmit_count - tx_base_reg)
                    >= {{(stcs_pkg::CNT_W-stcs_pkg::REQ_W){1'b0}}, req_tx_reg};
        chk_ok[3] = hs_sum > rx_base_reg;
        chk_ok[4] = s1_reg.solenoid_ok;
    end

    // Time left before the overall deadline is positive only while elapsed is
    // below it, so the twenty low bits of the difference are then exact.
    always_comb
    begin
        elapsed   = s1_reg.now_ms - start_time_reg;
        spent     = s1_reg.now_ms - chk_start_reg;
        expired   = elapsed >= {{(TW-MW){1'b0}}, deadline_reg};
        left      = deadline_reg - elapsed[MW-1:0];
        first_idx = phase_reg[2:0] - 3'd1;
    end

    always_comb
    begin
        found    = 1'b0;
        fail_idx = 3'd0;
        for (int i = 0; i < N; i++)
        begin
            if (!found && 3'(i) >= first_idx && !chk_ok[i])
            begin
                found    = 1'b1;
                fail_idx = 3'(i);
            end
        end
    end

    always_comb
    begin
        fail_to = timeout_reg[fail_idx];
        // A check started on this item has spent nothing, so it fails only on a
        // zero budget.
        if (fail_idx == first_idx)
        begin
            fails = {{(TW-MW){1'b0}}, budget_reg} <= spent;
        end
        else
        begin
            fails = (fail_to == '0) || expired;
        end
        start_budget = (timeout_reg[0] < deadline_reg) ? timeout_reg[0] : deadline_reg;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        pass_next       = pass_reg;
        start_time_next = start_time_reg;
        chk_start_next  = chk_start_reg;
        budget_next     = budget_reg;
        tx_base_next    = tx_base_reg;
        rx_base_next    = rx_base_reg;
        out_next.confirm_pulse = 1'b0;
        out_next.reboot_pulse  = 1'b0;

        if (s1_reg.cmd == stcs_pkg::CMD_START)
        begin
            start_time_next = s1_reg.now_ms;
            chk_start_next  = s1_reg.now_ms;
            tx_base_next    = s1_reg.transmit_count;
            rx_base_next    = hs_sum;
            pass_next       = '0;
            phase_next      = stcs_pkg::PH_CELLS;
            budget_next     = start_budget;
        end
        else if (phase_reg inside {[stcs_pkg::PH_CELLS : stcs_pkg::PH_SOLENOID]})
        begin
            for (int i = 0; i < N; i++)
            begin
                if (3'(i) >= first_idx && (!found || 3'(i) < fail_idx))
                begin
                    pass_next[i] = 1'b1;
                end
            end
            if (!found)
            begin
                phase_next             = stcs_pkg::PH_CONFIRMED;
                out_next.confirm_pulse = 1'b1;
            end
            else if (fails)
            begin
                phase_next            = expired ? stcs_pkg::PH_TIMEOUT
                                      : stcs_pkg::PH_FAIL_CELLS + {1'b0, fail_idx};
                out_next.reboot_pulse = 1'b1;
            end
            else if (fail_idx != first_idx)
            begin
                phase_next     = stcs_pkg::PH_CELLS + {1'b0, fail_idx};
                chk_start_next = s1_reg.now_ms;
                budget_next    = expired ? '0 : ((fail_to < left) ? fail_to : left);
            end
        end

        out_next.phase      = phase_next;
        out_next.pass_flags = pass_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= stcs_pkg::PH_IDLE;
            pass_reg       <= '0;
            start_time_reg <= '0;
            chk_start_reg  <= '0;
            budget_reg     <= '0;
            tx_base_reg    <= '0;
            rx_base_reg    <= '0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire)
            begin
                phase_reg      <= phase_next;
                pass_reg       <= pass_next;
                start_time_reg <= start_time_next;
                chk_start_reg  <= chk_start_next;
                budget_reg     <= budget_next;
                tx_base_reg    <= tx_base_next;
                rx_base_reg    <= rx_base_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_reg <= in_ch.data;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/stcs_checker.sv
`default_nettype none

module stcs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [stcs_pkg::PHASE_W-1:0]      phase,
    input wire logic [stcs_pkg::NUM_CHECKS-1:0]   pass_flags,
    input wire logic                              confirm_pulse,
    input wire logic                              reboot_pulse
);

    // A result never both confirms and reboots.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(confirm_pulse && reboot_pulse))
        else $error("confirm and reboot raised together");

    // Confirmation only once every check has passed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && confirm_pulse) |->
            (phase == stcs_pkg::PH_CONFIRMED && pass_flags == '1))
        else $error("confirm without full pass flags");

    // A reboot always lands in a timeout or failure phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reboot_pulse) |->
            (phase >= stcs_pkg::PH_TIMEOUT && phase <= stcs_pkg::PH_FAIL_LAST))
        else $error("reboot outside a failure phase");

    // A stalled result holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(phase) && $stable(pass_flags)
             && $stable(confirm_pulse) && $stable(reboot_pulse)))
        else $error("stalled result changed");

endmodule

bind self_test_confirm_sequencer stcs_checker u_stcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .phase         (out_ch.data.phase),
    .pass_flags    (out_ch.data.pass_flags),
    .confirm_pulse (out_ch.data.confirm_pulse),
    .reboot_pulse  (out_ch.data.reboot_pulse)
);

`default_nettype wire

FILE: tb/confirm_sequence_checker.sv
module confirm_sequence_checker
    import stcs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    stcs_in_if                         in_ch,
    stcs_out_if                        out_ch,
    output int                         errors,
    output int                         pending,
    output int                         results,
    output int                         confirms,
    output int                         reboots
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies
    logic [MS_W-1:0]       deadline_cfg;
    logic [MS_W-1:0]       tmo_cfg [NUM_CHECKS];
    logic [REQ_W-1:0]      req_cfg;
    logic [CELLS_W-1:0]    cells_cfg;

    // Sequencer state as this side sees it
    logic [PHASE_W-1:0]    phase_q;
    logic [NUM_CHECKS-1:0] passed_q;
    logic [TIME_W-1:0]     seq_start;
    logic [TIME_W-1:0]     chk_origin;
    logic [MS_W-1:0]       budget_q;
    logic [CNT_W-1:0]      tx_base;
    logic [CNT_W-1:0]      rx_base;

    out_item_t             outcome_q [$];
    out_item_t             want;
    out_item_t             got;
    int                    fail_cnt;
    int                    result_cnt;
    int                    confirm_cnt;
    int                    reboot_cnt;

    // Time left before the overall deadline; negative once it has passed.
    function automatic longint time_left(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        elapsed = now - seq_start;
        return longint'(deadline_cfg) - longint'(elapsed);
    endfunction

    function automatic void begin_check(input int idx, input logic [TIME_W-1:0] now);
        longint left;
        longint b;
        left = time_left(now);
        b = longint'(tmo_cfg[idx]);
        if (left < b)
        begin
            b = left;
        end
        if (b < 0)
        begin
            b = 0;
        end
        budget_q = b[MS_W-1:0];
        chk_origin = now;
    endfunction

    function automatic logic [CNT_W-1:0] bus_total(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic check_ok(input int idx, input in_item_t it);
        logic ok;
        case (idx)
            0:
            begin
                // A cell count of zero still checks cell one.
                ok = it.cell_one_ok;
                if (cells_cfg >= 2)
                begin
                    ok = ok & it.cell_two_ok;
                end
                if (cells_cfg >= 3)
                begin
                    ok = ok & it.cell_three_ok;
                end
            end
            1: ok = it.consensus_ok;
            2: ok = (it.transmit_count - tx_base) >= {{(CNT_W-REQ_W){1'b0}}, req_cfg};
            3: ok = bus_total(it.bus_init_count, it.bus_id_count) > rx_base;
            default: ok = it.solenoid_ok;
        endcase
        return ok;
    endfunction

    function automatic out_item_t next_outcome(input in_item_t it);
        out_item_t r;
        int        idx;
        logic      done;
        r = '0;
        if (it.cmd == CMD_START)
        begin
            seq_start = it.now_ms;
            tx_base   = it.transmit_count;
            rx_base   = bus_total(it.bus_init_count, it.bus_id_count);
            passed_q  = '0;
            phase_q   = PH_CELLS;
            begin_check(0, it.now_ms);
        end
        else
        begin
            // Checks that pass hand over to the next one within the same poll.
            done = 1'b0;
            while (!done && phase_q >= PH_CELLS && phase_q <= PH_SOLENOID)
            begin
                idx = phase_q - PH_CELLS;
                if (check_ok(idx, it))
                begin
                    passed_q[idx] = 1'b1;
                    if (phase_q == PH_SOLENOID)
                    begin
                        phase_q = PH_CONFIRMED;
                        r.confirm_pulse = 1'b1;
                    end
                    else
                    begin
                        phase_q = phase_q + 4'd1;
                        begin_check(idx + 1, it.now_ms);
                    end
                end
                else
                begin
                    if (it.now_ms - chk_origin >= {{(TIME_W-MS_W){1'b0}}, budget_q})
                    begin
                        if (time_left(it.now_ms) <= 0)
                        begin
                            phase_q = PH_TIMEOUT;
                        end
                        else
                        begin
                            phase_q = PH_FAIL_CELLS + idx[PHASE_W-1:0];
                        end
                        r.reboot_pulse = 1'b1;
                    end
                    done = 1'b1;
                end
            end
        end
        r.phase      = phase_q;
        r.pass_flags = passed_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_cfg = DEADLINE_RST;
            for (int k = 0; k < NUM_CHECKS; k++)
            begin
                tmo_cfg[k] = TIMEOUT_RST;
            end
            req_cfg     = REQ_TX_RST;
            cells_cfg   = CELLS_RST;
            phase_q     = PH_IDLE;
            passed_q    = '0;
            seq_start   = '0;
            chk_origin  = '0;
            budget_q    = '0;
            tx_base     = '0;
            rx_base     = '0;
            outcome_q.delete();
            fail_cnt    = 0;
            result_cnt  = 0;
            confirm_cnt = 0;
            reboot_cnt  = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DEADLINE:  deadline_cfg = cfg_data;
                    CFG_CELL_TO:   tmo_cfg[0]   = cfg_data;
                    CFG_CONS_TO:   tmo_cfg[1]   = cfg_data;
                    CFG_TX_TO:     tmo_cfg[2]   = cfg_data;
                    CFG_HS_TO:     tmo_cfg[3]   = cfg_data;
                    CFG_SOL_TO:    tmo_cfg[4]   = cfg_data;
                    CFG_REQ_TX:    req_cfg      = cfg_data[REQ_W-1:0];
                    CFG_CELLS_USE: cells_cfg    = cfg_data[CELLS_W-1:0];
                    default: ;
                endcase
            end

            if (in_ch.valid && in_ch.ready)
            begin
                outcome_q.push_back(next_outcome(in_ch.data));
            end

            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                result_cnt++;
                if (got.confirm_pulse === 1'b1)
                begin
                    confirm_cnt++;
                end
                if (got.reboot_pulse === 1'b1)
                begin
                    reboot_cnt++;
                end
                if (outcome_q.size() == 0)
                begin
                    $error("result transfer with nothing outstanding: phase %0d, pass_flags %b",
                           got.phase, got.pass_flags);
                    fail_cnt++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.phase !== want.phase)
                    begin
                        $error("phase: expected %0d, actual %0d", want.phase, got.phase);
                        fail_cnt++;
                    end
                    if (got.pass_flags !== want.pass_flags)
                    begin
                        $error("pass_flags: expected %b, actual %b",
                               want.pass_flags, got.pass_flags);
                        fail_cnt++;
                    end
                    if (got.confirm_pulse !== want.confirm_pulse)
                    begin
                        $error("confirm_pulse: expected %b, actual %b",
                               want.confirm_pulse, got.confirm_pulse);
                        fail_cnt++;
                    end
                    if (got.reboot_pulse !== want.reboot_pulse)
                    begin
                        $error("reboot_pulse: expected %b, actual %b",
                               want.reboot_pulse, got.reboot_pulse);
                        fail_cnt++;
                    end
                end
            end
        end

        // Counts leave here through nonblocking updates, so the stimulus side
        // always reads the value settled at the previous edge.
        errors   <= fail_cnt;
        pending  <= outcome_q.size();
        results  <= result_cnt;
        confirms <= confirm_cnt;
        reboots  <= reboot_cnt;
    end

endmodule

FILE: tb/self_test_confirm_sequencer_tb.sv
module self_test_confirm_sequencer_tb;
    import stcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SETTINGS      = 8;
    localparam int ITEMS_PER_SETTING = 90;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stcs_in_if  in_ch ();
    stcs_out_if out_ch ();

    int err_count;
    int pending;
    int result_count;
    int confirm_count;
    int reboot_count;
    int idle_pct  = 0;
    int stall_pct = 0;
    int items_sent;

    // Snapshot of the system under self-test, advanced poll by poll.
    logic [TIME_W-1:0] clock_ms;
    logic [CNT_W-1:0]  frames_tx;
    logic [CNT_W-1:0]  init_msgs;
    logic [CNT_W-1:0]  id_msgs;

    self_test_confirm_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    confirm_sequence_checker outcome_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .errors    (err_count),
        .pending   (pending),
        .results   (result_count),
        .confirms  (confirm_count),
        .reboots   (reboot_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Flags are ordered cell one, cell two, cell three, consensus, solenoid.
    function automatic in_item_t make_item(input logic c, input logic [TIME_W-1:0] now,
                                           input logic [4:0] flags,
                                           input logic [CNT_W-1:0] tx,
                                           input logic [CNT_W-1:0] bi,
                                           input logic [CNT_W-1:0] bd);
        in_item_t it;
        it.cmd = c;
        it.now_ms = now;
        {it.cell_one_ok, it.cell_two_ok, it.cell_three_ok,
         it.consensus_ok, it.solenoid_ok} = flags;
        it.transmit_count = tx;
        it.bus_init_count = bi;
        it.bus_id_count = bd;
        return it;
    endfunction

    function automatic logic [4:0] random_flags(input int good_pct);
        logic [4:0] f;
        for (int k = 0; k < 5; k++)
        begin
            f[k] = ($urandom_range(99) < good_pct);
        end
        return f;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input int sel);
        logic [MS_W-1:0]    dl;
        logic [MS_W-1:0]    tmo [NUM_CHECKS];
        logic [REQ_W-1:0]   req;
        logic [CELLS_W-1:0] cells;
        case (sel)
            0:
            begin
                dl = '0;
                for (int k = 0; k < NUM_CHECKS; k++)
                begin
                    tmo[k] = '0;
                end
                req = '0;
                cells = '0;
            end
            1:
            begin
                dl = '1;
                for (int k = 0; k < NUM_CHECKS; k++)
                begin
                    tmo[k] = '1;
                end
                req = '1;
                cells = 2'd3;
            end
            2:
            begin
                dl = 20'd1000000;
                for (int k = 0; k < NUM_CHECKS; k++)
                begin
                    tmo[k] = 20'd1000000;
                end
                req = 8'd1;
                cells = 2'd1;
            end
            default:
            begin
                // Short budgets so that timeouts and faults come within a few polls.
                dl = MS_W'($urandom_range(150));
                for (int k = 0; k < NUM_CHECKS; k++)
                begin
                    tmo[k] = MS_W'(($urandom_range(9) == 0) ? $urandom_range(5000)
                                                             : $urandom_range(40));
                end
                req = REQ_W'($urandom_range(4));
                cells = CELLS_W'($urandom_range(3));
            end
        endcase
        set_reg(CFG_DEADLINE, dl);
        set_reg(CFG_CELL_TO, tmo[0]);
        set_reg(CFG_CONS_TO, tmo[1]);
        set_reg(CFG_TX_TO, tmo[2]);
        set_reg(CFG_HS_TO, tmo[3]);
        set_reg(CFG_SOL_TO, tmo[4]);
        set_reg(CFG_REQ_TX, {{(CFG_DATA_W-REQ_W){1'b0}}, req});
        set_reg(CFG_CELLS_USE, {{(CFG_DATA_W-CELLS_W){1'b0}}, cells});
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Runs with the reset register values.
    task automatic run_directed();
        send_item(make_item(CMD_POLL,  32'd0, 5'b11111, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_START, 32'd0, 5'b00000, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_POLL,  32'd1, 5'b11111, 32'd3, 32'd1, 32'd0));
        send_item(make_item(CMD_POLL,  32'd2, 5'b00000, 32'd0, 32'd0, 32'd0));
        // Wrapping clock and transmit count; the saturated receive sum can never grow.
        send_item(make_item(CMD_START, '1, 5'b11111, '1, '1, '1));
        send_item(make_item(CMD_POLL,  32'd5, 5'b11111, 32'd2, '1, '1));
        send_item(make_item(CMD_POLL,  32'd10005, 5'b11111, 32'd2, '1, '1));
        send_item(make_item(CMD_START, 32'd100, 5'b00000, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_POLL,  32'd10100, 5'b01111, 32'd0, 32'd0, 32'd0));
        // Consensus budget cut to what is left of the deadline, then a timeout.
        send_item(make_item(CMD_START, 32'd0, 5'b00000, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_POLL,  32'd55000, 5'b11101, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_POLL,  32'd60000, 5'b11101, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_START, 32'd0, 5'b00000, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_POLL,  32'd1, 5'b11101, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_POLL,  32'd10001, 5'b11101, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_START, 32'd0, 5'b00000, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_POLL,  32'd1, 5'b11111, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_POLL,  32'd10001, 5'b11111, 32'd2, 32'd0, 32'd0));
        send_item(make_item(CMD_START, 32'd0, 5'b00000, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_POLL,  32'd1, 5'b11110, 32'd3, 32'd0, 32'd1));
        send_item(make_item(CMD_POLL,  32'd10001, 5'b11110, 32'd3, 32'd0, 32'd1));
        // A start in the middle of a check begins the sequence again.
        send_item(make_item(CMD_START, 32'd0, 5'b00000, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_POLL,  32'd1, 5'b10111, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_START, 32'd2, 5'b11111, 32'd0, 32'd0, 32'd0));
        send_item(make_item(CMD_POLL,  32'd3, 5'b11011, 32'd0, 32'd0, 32'd0));
    endtask

    task automatic run_sequence(input int polls);
        int good;
        clock_ms  = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(40) : $urandom;
        frames_tx = ($urandom_range(1) == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(3);
        case ($urandom_range(4))
            0:
            begin
                init_msgs = $urandom;
                id_msgs = $urandom;
            end
            1:
            begin
                init_msgs = 32'hFFFF_FFFF - $urandom_range(2);
                id_msgs = $urandom_range(2);
            end
            default:
            begin
                init_msgs = $urandom_range(3);
                id_msgs = $urandom_range(3);
            end
        endcase
        good = $urandom_range(55, 97);
        send_item(make_item(CMD_START, clock_ms, random_flags(50), frames_tx, init_msgs, id_msgs));
        for (int n = 0; n < polls; n++)
        begin
            case ($urandom_range(9))
                0:       clock_ms += $urandom_range(2000000);
                1, 2:    clock_ms += $urandom_range(3000);
                default: clock_ms += $urandom_range(20);
            endcase
            frames_tx += ($urandom_range(4) == 0) ? $urandom_range(400) : $urandom_range(2);
            if ($urandom_range(3) == 0)
            begin
                init_msgs += 1;
            end
            if ($urandom_range(3) == 0)
            begin
                id_msgs += 1;
            end
            send_item(make_item(CMD_POLL, clock_ms, random_flags(good),
                                frames_tx, init_msgs, id_msgs));
        end
    endtask

    initial
    begin
        int target;
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        cfg_write   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        items_sent  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            configure(p);
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 60;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 60;
                end
                default:
                begin
                    idle_pct = 24;
                    stall_pct = 24;
                end
            endcase
            target = items_sent + ITEMS_PER_SETTING;
            while (items_sent < target)
            begin
                if ($urandom_range(99) < 12)
                begin
                    // Unrelated traffic: mostly stray polls, now and then a random start.
                    send_item(make_item($urandom_range(3) != 0, $urandom,
                                        5'($urandom_range(31)),
                                        $urandom, $urandom, $urandom));
                end
                else
                begin
                    run_sequence($urandom_range(1, 8));
                end
            end
            idle_pct = 0;
            stall_pct = 0;
            drain();
        end

        $display("Self-test sequencer: %0d items over %0d register settings",
                 items_sent, NUM_SETTINGS + 1);
        $display("and four idling patterns; %0d results compared, %0d confirms, %0d reboots.",
                 result_count, confirm_count, reboot_count);
        if (err_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
